### design/sfef_pkg.sv
// ----------------------------------------------------------------------------
// sfef_pkg
// Types and constants of the structure function error factor block.
// ----------------------------------------------------------------------------
package sfef_pkg;

   localparam int TIME_W   = 32;
   localparam int RES_W    = 24;
   localparam int ERR_W    = 24;
   localparam int GAP_W    = 16;
   localparam int FACTOR_W = 24;
   localparam int PAIR_W   = 20;
   localparam int SUM_W    = 64;
   localparam int ENTRY_W  = TIME_W + RES_W + ERR_W;
   // pairs * error sum, and its multiples used by the root search
   localparam int PE_W     = PAIR_W + SUM_W;
   localparam int QA_W     = FACTOR_W + PE_W;
   localparam int LHS_W    = 2 * FACTOR_W + PE_W;
   localparam int MUL_W    = 32;

   localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

   typedef struct packed {
      logic        [ERR_W-1:0]  err;
      logic signed [RES_W-1:0]  res;
      logic signed [TIME_W-1:0] tim;
   } entry_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_START,
      ST_SORT_FIRST,
      ST_SORT_CMP,
      ST_SORT_END,
      ST_SCAN_INIT,
      ST_SCAN_I,
      ST_SCAN_IW,
      ST_SCAN_J,
      ST_SCAN_JW,
      ST_MUL,
      ST_MUL_WAIT,
      ST_SQ_A,
      ST_SQ_B,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MS_PE_LO,
      MS_PE_HI,
      MS_SC_LO,
      MS_SC_HI
   } mul_step_type;

endpackage

### design/sfef_ram.sv
// ----------------------------------------------------------------------------
// sfef_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sfef_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/structure_function_error_factor_top.sv
// ----------------------------------------------------------------------------
// structure_function_error_factor_top
// Loads a set of timed samples, sorts them by time in memory, sums squared
// errors and squared residual differences of close pairs, then returns the
// noise ratio sqrt(sf * count / (2 * pairs * verr)) in Q8.16.
// ----------------------------------------------------------------------------
//  channel | ports           | word
//  --------+-----------------+-----------------------------------------------
//  req     | req_t*          | time, residual, error; tlast closes the set
//  rsp     | rsp_t*          | factor, pair count; tuser = invalid
//  csr     | csr_valid/ready | day_gap
//
// Loading takes one sample per cycle. After the last sample the sort runs
// passes through the sample RAM port until a pass makes no swap, then the pair
// scan reads the sorted samples, the product step forms pairs * verr and
// count * sf, and the root search finds the factor bit by bit. No samples are
// taken while computing. A pending result does not block loading of the next
// set. Reset is synchronous; RAM contents are not cleared.
module structure_function_error_factor_top #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample_time [31:0], residual [55:32], measure_error [79:56]
   input  logic [79:0] req_tdata,
   // last_sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // error_factor [23:0], pair_count [43:24], zero fill [47:44]
   output logic [47:0] rsp_tdata,
   // invalid
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int BW = sfef_pkg::SUM_W + CW;

   sfef_pkg::state_type state_ff, state_in;

   logic [sfef_pkg::GAP_W-1:0]   day_gap_ff;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [CW-1:0]                k_ff, k_in;
   logic [CW-1:0]                i_ff, i_in;
   logic [CW-1:0]                j_ff, j_in;
   logic                         moved_ff, moved_in;
   sfef_pkg::entry_type          cur_ff, cur_in;
   logic signed [sfef_pkg::TIME_W-1:0] ti_ff, ti_in;
   logic signed [sfef_pkg::RES_W-1:0]  ri_ff, ri_in;

   logic [2*sfef_pkg::ERR_W-1:0] ep_ff;
   logic                         ev_ff, eclr_ff;
   logic [sfef_pkg::SUM_W-1:0]   verr_ff;
   logic [49:0]                  sq_ff, sq_in;
   logic                         sqv_ff, sqv_in;
   logic [sfef_pkg::SUM_W-1:0]   sf_ff;
   logic                         sf_clr;
   logic [sfef_pkg::PAIR_W-1:0]  pairs_ff, pairs_in;

   logic [1:0]                   step_ff, step_in;
   logic [2*sfef_pkg::MUL_W-1:0] mp_ff, mp_in;
   logic [1:0]                   mtag_ff;
   logic                         mv_ff, mv_in;
   logic [sfef_pkg::PE_W-1:0]    a_ff;
   logic [BW-1:0]                bm_ff;

   logic [sfef_pkg::FACTOR_W-1:0] q_ff, q_in;
   logic [sfef_pkg::QA_W-1:0]     qa_ff, qa_in;
   logic [sfef_pkg::LHS_W-1:0]    q2a_ff, q2a_in;
   logic [sfef_pkg::LHS_W-1:0]    t_ff, t_in;
   logic [4:0]                    bit_ff, bit_in;
   logic                          invalid_ff, invalid_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [47:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr, rd_addr;
   sfef_pkg::entry_type           wr_entry, rd_entry;
   logic [sfef_pkg::ENTRY_W-1:0]  rd_word;

   logic                          req_fire, store_ok, out_load;
   logic                          swap;
   logic signed [32:0]            tdiff;
   logic [32:0]                   tabs;
   logic                          in_win;
   logic signed [24:0]            rdiff;
   logic [24:0]                   rabs;
   logic [sfef_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic [sfef_pkg::LHS_W-1:0]    cand, rhs;
   logic                          zero_path;

   sfef_ram #(
      .WIDTH(sfef_pkg::ENTRY_W),
      .DEPTH(MAX_SAMPLES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   assign rd_entry   = rd_word;
   assign req_tready = (state_ff == sfef_pkg::ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign store_ok   = (cnt_ff < CW'(MAX_SAMPLES));
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign swap   = (rd_entry.tim < cur_ff.tim);
   assign tdiff  = 33'(rd_entry.tim) - 33'(ti_ff);
   assign tabs   = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
   assign in_win = (tabs < {1'b0, day_gap_ff, 16'd0});
   assign rdiff  = 25'(ri_ff) - 25'(rd_entry.res);
   assign rabs   = rdiff[24] ? 25'(-rdiff) : 25'(rdiff);

   assign cand = t_ff + (sfef_pkg::LHS_W'(a_ff) << {bit_ff, 1'b0});
   assign rhs  = sfef_pkg::LHS_W'(bm_ff) << 31;
   assign zero_path = (pairs_ff == '0) || (verr_ff == '0);

   always_comb begin
      unique case (sfef_pkg::mul_step_type'(step_ff))
         sfef_pkg::MS_PE_LO: begin
            mul_a = sfef_pkg::MUL_W'(pairs_ff);
            mul_b = verr_ff[31:0];
         end
         sfef_pkg::MS_PE_HI: begin
            mul_a = sfef_pkg::MUL_W'(pairs_ff);
            mul_b = verr_ff[63:32];
         end
         sfef_pkg::MS_SC_LO: begin
            mul_a = sfef_pkg::MUL_W'(cnt_ff);
            mul_b = sf_ff[31:0];
         end
         default: begin
            mul_a = sfef_pkg::MUL_W'(cnt_ff);
            mul_b = sf_ff[63:32];
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfef_pkg::ST_LOAD: begin
            if (req_fire && req_tlast) state_in = sfef_pkg::ST_SORT_START;
         end
         sfef_pkg::ST_SORT_START: begin
            state_in = (cnt_ff < CW'(2)) ? sfef_pkg::ST_SCAN_INIT : sfef_pkg::ST_SORT_FIRST;
         end
         sfef_pkg::ST_SORT_FIRST: state_in = sfef_pkg::ST_SORT_CMP;
         sfef_pkg::ST_SORT_CMP: begin
            if (k_ff == cnt_ff - CW'(1)) state_in = sfef_pkg::ST_SORT_END;
         end
         sfef_pkg::ST_SORT_END: begin
            state_in = (moved_ff || swap && 1'b0) ? sfef_pkg::ST_SORT_START
                                                  : sfef_pkg::ST_SCAN_INIT;
         end
         sfef_pkg::ST_SCAN_INIT: state_in = sfef_pkg::ST_SCAN_I;
         sfef_pkg::ST_SCAN_I: begin
            state_in = (i_ff >= cnt_ff) ? sfef_pkg::ST_MUL : sfef_pkg::ST_SCAN_IW;
         end
         sfef_pkg::ST_SCAN_IW: state_in = sfef_pkg::ST_SCAN_J;
         sfef_pkg::ST_SCAN_J: begin
            state_in = (j_ff >= cnt_ff) ? sfef_pkg::ST_SCAN_I : sfef_pkg::ST_SCAN_JW;
         end
         sfef_pkg::ST_SCAN_JW: begin
            state_in = in_win ? sfef_pkg::ST_SCAN_J : sfef_pkg::ST_SCAN_I;
         end
         sfef_pkg::ST_MUL: begin
            if (step_ff == 2'(sfef_pkg::MS_SC_HI)) state_in = sfef_pkg::ST_MUL_WAIT;
         end
         sfef_pkg::ST_MUL_WAIT: begin
            state_in = zero_path ? sfef_pkg::ST_OUT : sfef_pkg::ST_SQ_A;
         end
         sfef_pkg::ST_SQ_A: state_in = sfef_pkg::ST_SQ_B;
         sfef_pkg::ST_SQ_B: begin
            state_in = (bit_ff == 5'd0) ? sfef_pkg::ST_OUT : sfef_pkg::ST_SQ_A;
         end
         sfef_pkg::ST_OUT: begin
            if (out_load) state_in = sfef_pkg::ST_LOAD;
         end
         default: state_in = sfef_pkg::ST_LOAD;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      moved_in    = moved_ff;
      cur_in      = cur_ff;
      ti_in       = ti_ff;
      ri_in       = ri_ff;
      sq_in       = sq_ff;
      sqv_in      = 1'b0;
      sf_clr      = 1'b0;
      pairs_in    = pairs_ff;
      step_in     = step_ff;
      mp_in       = mp_ff;
      mv_in       = 1'b0;
      q_in        = q_ff;
      qa_in       = qa_ff;
      q2a_in      = q2a_ff;
      t_in        = t_ff;
      bit_in      = bit_ff;
      invalid_in  = invalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[AW-1:0];
      wr_entry    = cur_ff;
      rd_addr     = '0;
      unique case (state_ff)
         sfef_pkg::ST_LOAD: begin
            wr_entry = req_tdata;
            if (req_fire && store_ok) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         sfef_pkg::ST_SORT_START: begin
            rd_addr  = '0;
            k_in     = CW'(1);
            moved_in = 1'b0;
         end
         sfef_pkg::ST_SORT_FIRST: begin
            cur_in  = rd_entry;
            rd_addr = k_ff[AW-1:0];
         end
         sfef_pkg::ST_SORT_CMP: begin
            // carry the larger time forward, drop the smaller behind it
            wr_en    = 1'b1;
            wr_addr  = AW'(k_ff - CW'(1));
            wr_entry = swap ? rd_entry : cur_ff;
            cur_in   = swap ? cur_ff : rd_entry;
            moved_in = moved_ff || swap;
            k_in     = k_ff + CW'(1);
            rd_addr  = AW'(k_ff + CW'(1));
         end
         sfef_pkg::ST_SORT_END: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(cnt_ff - CW'(1));
            wr_entry = cur_ff;
         end
         sfef_pkg::ST_SCAN_INIT: begin
            i_in     = '0;
            sf_clr   = 1'b1;
            pairs_in = '0;
         end
         sfef_pkg::ST_SCAN_I: begin
            rd_addr = i_ff[AW-1:0];
         end
         sfef_pkg::ST_SCAN_IW: begin
            ti_in = rd_entry.tim;
            ri_in = rd_entry.res;
            j_in  = i_ff + CW'(1);
         end
         sfef_pkg::ST_SCAN_J: begin
            rd_addr = j_ff[AW-1:0];
            if (j_ff >= cnt_ff) i_in = i_ff + CW'(1);
         end
         sfef_pkg::ST_SCAN_JW: begin
            if (in_win) begin
               sq_in  = 50'(rabs) * 50'(rabs);
               sqv_in = 1'b1;
               if (pairs_ff != sfef_pkg::PAIR_MAX) pairs_in = pairs_ff + 1'b1;
               j_in = j_ff + CW'(1);
            end else begin
               // jump to the first sample outside the window
               i_in = j_ff;
            end
         end
         sfef_pkg::ST_MUL: begin
            mp_in   = mul_a * mul_b;
            mv_in   = 1'b1;
            step_in = step_ff + 2'd1;
         end
         sfef_pkg::ST_MUL_WAIT: begin
            invalid_in = zero_path;
            q_in   = '0;
            qa_in  = '0;
            q2a_in = '0;
            bit_in = 5'(sfef_pkg::FACTOR_W - 1);
         end
         sfef_pkg::ST_SQ_A: begin
            t_in = q2a_ff + (sfef_pkg::LHS_W'(qa_ff) << (6'(bit_ff) + 6'd1));
         end
         sfef_pkg::ST_SQ_B: begin
            if (cand <= rhs) begin
               q_in   = q_ff | (sfef_pkg::FACTOR_W'(1) << bit_ff);
               q2a_in = cand;
               qa_in  = qa_ff + (sfef_pkg::QA_W'(a_ff) << bit_ff);
            end
            bit_in = bit_ff - 5'd1;
         end
         sfef_pkg::ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, pairs_ff, q_ff};
               rsp_user_in  = invalid_ff;
               cnt_in       = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfef_pkg::ST_LOAD;
         day_gap_ff   <= sfef_pkg::GAP_W'(1);
         cnt_ff       <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         moved_ff     <= 1'b0;
         ev_ff        <= 1'b0;
         eclr_ff      <= 1'b0;
         sqv_ff       <= 1'b0;
         mv_ff        <= 1'b0;
         step_ff      <= '0;
         bit_ff       <= '0;
         invalid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         verr_ff      <= '0;
         sf_ff        <= '0;
         pairs_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) day_gap_ff <= csr_data;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         moved_ff     <= moved_in;
         ev_ff        <= req_fire && store_ok;
         eclr_ff      <= (cnt_ff == '0);
         sqv_ff       <= sqv_in;
         mv_ff        <= mv_in;
         step_ff      <= (state_ff == sfef_pkg::ST_MUL) ? step_in : '0;
         bit_ff       <= bit_in;
         invalid_ff   <= invalid_in;
         rsp_valid_ff <= rsp_valid_in;
         pairs_ff     <= pairs_in;
         // error sum builds up while the set loads, order does not matter
         if (ev_ff) begin
            logic [sfef_pkg::SUM_W:0] es;
            es = {1'b0, (eclr_ff ? {sfef_pkg::SUM_W{1'b0}} : verr_ff)} + 65'(ep_ff);
            verr_ff <= es[sfef_pkg::SUM_W] ? '1 : es[sfef_pkg::SUM_W-1:0];
         end
         if (sf_clr) begin
            sf_ff <= '0;
         end else if (sqv_ff) begin
            logic [sfef_pkg::SUM_W:0] ss;
            ss = {1'b0, sf_ff} + 65'(sq_ff);
            sf_ff <= ss[sfef_pkg::SUM_W] ? '1 : ss[sfef_pkg::SUM_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ep_ff       <= 48'(req_tdata[79:56]) * 48'(req_tdata[79:56]);
      cur_ff      <= cur_in;
      ti_ff       <= ti_in;
      ri_ff       <= ri_in;
      sq_ff       <= sq_in;
      mp_ff       <= mp_in;
      mtag_ff     <= step_ff;
      q_ff        <= q_in;
      qa_ff       <= qa_in;
      q2a_ff      <= q2a_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (mv_ff) begin
         unique case (sfef_pkg::mul_step_type'(mtag_ff))
            sfef_pkg::MS_PE_LO: a_ff  <= sfef_pkg::PE_W'(mp_ff);
            sfef_pkg::MS_PE_HI: a_ff  <= a_ff + (sfef_pkg::PE_W'(mp_ff) << 32);
            sfef_pkg::MS_SC_LO: bm_ff <= BW'(mp_ff);
            default:            bm_ff <= bm_ff + (BW'(mp_ff) << 32);
         endcase
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SAMPLES))
      else $error("sample count above store depth");

   a_sort_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfef_pkg::ST_SORT_CMP) |-> (k_ff < cnt_ff && k_ff != '0))
      else $error("sort index outside the set");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfef_pkg::ST_SCAN_JW) |-> (j_ff > i_ff && j_ff < cnt_ff))
      else $error("pair scan index out of order");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sfef_pkg::ST_OUT && out_load) |=>
         (rsp_tuser == ((pairs_ff == '0) || (verr_ff == '0))))
      else $error("invalid flag does not match sums");

endmodule
